// ===== rtl/vrm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the voxel ray march block.
package vrm_pkg;

   localparam int GRID_BITS = 5;
   localparam int FRAC_BITS = 8;
   localparam int MAP_AW    = 3 * GRID_BITS;
   localparam int FIELD_W   = 16;
   localparam int COORD_W   = 20;                    // point, with room for overshoot
   localparam int CELL_W    = COORD_W - FRAC_BITS;   // cell index, signed
   localparam int DIFF_W    = FRAC_BITS + 1;         // distance to next plane
   localparam int LEN_W     = 16;
   localparam int TRAV_W    = LEN_W + 2;
   localparam int DIV_W     = 32;
   localparam int DVS_W     = FIELD_W + 1;
   localparam int CNT_W     = 5;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CAST  = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SQ,
      ST_SQRT,
      ST_LOOP,
      ST_PLAN,
      ST_PWAIT,
      ST_ADV,
      ST_AWAIT,
      ST_CELL,
      ST_MREQ,
      ST_MCHK,
      ST_FINISH
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_WRITE,
      DP_LOAD,
      DP_SQ,
      DP_SQRT,
      DP_STEP_INIT,
      DP_PLAN_START,
      DP_PLAN_TAKE,
      DP_ADV_SET,
      DP_ADV_START,
      DP_ADV_TAKE,
      DP_CELL,
      DP_MCHK,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic sqrt_last;
      logic trav_lt_len;
      logic dir_zero;
      logic chosen_fixed;
      logic div_done;
      logic hit_now;
   } dp_sts_type;

endpackage

// ===== rtl/vrm_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module vrm_div
   import vrm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] q_ff, q_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, q_ff[DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(rem_sh - {1'b0, dvs_ff});
            q_in   = {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            q_in   = {q_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== rtl/vrm_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: occupancy map, length root, step arithmetic and result register.
module vrm_dpath
   import vrm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_sts_type           sts,
   input  logic [GRID_BITS-1:0] cell_x,
   input  logic [GRID_BITS-1:0] cell_y,
   input  logic [GRID_BITS-1:0] cell_z,
   input  logic                 cell_solid,
   input  logic [FIELD_W-1:0]   origin_x,
   input  logic [FIELD_W-1:0]   origin_y,
   input  logic [FIELD_W-1:0]   origin_z,
   input  logic [FIELD_W-1:0]   dir_x,
   input  logic [FIELD_W-1:0]   dir_y,
   input  logic [FIELD_W-1:0]   dir_z,
   output logic                 rsp_hit,
   output logic [FIELD_W-1:0]   rsp_distance,
   output logic [4:0]           rsp_hit_x,
   output logic [4:0]           rsp_hit_y,
   output logic [4:0]           rsp_hit_z
);

   logic map_mem [0:(1 << MAP_AW)-1];
   logic              map_we;
   logic [MAP_AW-1:0] map_wa;
   logic              map_wd;
   logic [MAP_AW-1:0] map_ra;
   logic              rd_ff;

   logic signed [COORD_W-1:0] p_ff [0:2];
   logic signed [COORD_W-1:0] p_in [0:2];
   logic signed [FIELD_W-1:0] d_ff [0:2];
   logic signed [FIELD_W-1:0] d_in [0:2];
   logic signed [CELL_W-1:0]  c_ff [0:2];
   logic signed [CELL_W-1:0]  c_in [0:2];
   logic [DIV_W-1:0]  n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   logic [TRAV_W-1:0] trav_ff, trav_in;
   logic [1:0]        best_ff, best_in;
   logic [LEN_W-1:0]  bt_ff, bt_in;
   logic signed [COORD_W-1:0] bplane_ff, bplane_in;
   logic bclamp_ff, bclamp_in, bvalid_ff, bvalid_in, hit_ff, hit_in;
   logic [MAP_AW-1:0] clr_ff, clr_in;
   logic rsp_hit_ff, rsp_hit_in;
   logic [FIELD_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic [4:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;

   logic [LEN_W-1:0]          len;
   logic signed [FIELD_W-1:0] d_sel;
   logic signed [COORD_W-1:0] p_sel;
   logic signed [CELL_W-1:0]  c_sel;
   logic                      d_neg;
   logic signed [CELL_W-1:0]  plane_c;
   logic signed [COORD_W-1:0] plane_q, diff_full;
   logic [DIFF_W-1:0]         diff;
   logic signed [DVS_W-1:0]   d_ext;
   logic [DVS_W-1:0]          ad;
   logic [DIFF_W+LEN_W-1:0]   plan_prod;
   logic [DVS_W+LEN_W-1:0]    adv_prod;
   logic signed [DIV_W-1:0]   sq_prod;
   logic [DIV_W-1:0]          root_try;
   logic [DIV_W-1:0]          raw_t;
   logic [LEN_W-1:0]          t_clip;
   logic                      raw_over;
   logic [DVS_W-1:0]          step_q;
   logic                      in_grid;
   logic                      div_start, div_done;
   logic [DIV_W-1:0]          div_dividend, div_q;
   logic [DVS_W-1:0]          div_divisor;

   assign len   = r_ff[LEN_W-1:0];
   assign d_sel = d_ff[cmd.axis];
   assign p_sel = p_ff[cmd.axis];
   assign c_sel = c_ff[cmd.axis];
   assign d_neg = d_sel[FIELD_W-1];

   // next plane along the selected axis, with the on-face rule for negative rays
   always_comb begin
      if (!d_neg)
         plane_c = c_sel + 1'b1;
      else if ({c_sel, FRAC_BITS'(0)} == p_sel)
         plane_c = c_sel - 1'b1;
      else
         plane_c = c_sel;
      plane_q   = {plane_c, FRAC_BITS'(0)};
      diff_full = d_neg ? (p_sel - plane_q) : (plane_q - p_sel);
      diff      = diff_full[DIFF_W-1:0];
      d_ext     = DVS_W'(d_sel);
      ad        = d_neg ? DVS_W'(-d_ext) : DVS_W'(d_ext);
      plan_prod = diff * len;
      adv_prod  = ad * bt_ff;
      sq_prod   = d_sel * d_sel;
      root_try  = r_ff + bit_ff;
      raw_t     = div_q;
      raw_over  = raw_t > DIV_W'(len);
      t_clip    = raw_over ? len : raw_t[LEN_W-1:0];
      step_q    = div_q[DVS_W-1:0];
   end

   assign div_start    = (cmd.op == DP_PLAN_START) || (cmd.op == DP_ADV_START);
   assign div_dividend = (cmd.op == DP_PLAN_START) ? DIV_W'(plan_prod)
                                                   : adv_prod[DIV_W-1:0];
   assign div_divisor  = (cmd.op == DP_PLAN_START) ? ad : DVS_W'(len);

   vrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign map_ra = {c_ff[2][GRID_BITS-1:0], c_ff[1][GRID_BITS-1:0], c_ff[0][GRID_BITS-1:0]};
   assign in_grid = (c_ff[0][CELL_W-1:GRID_BITS] == '0) &&
                    (c_ff[1][CELL_W-1:GRID_BITS] == '0) &&
                    (c_ff[2][CELL_W-1:GRID_BITS] == '0);

   always_comb begin
      map_we = 1'b0;
      map_wa = clr_ff;
      map_wd = 1'b0;
      if (cmd.op == DP_CLEAR) begin
         map_we = 1'b1;
      end else if (cmd.op == DP_WRITE) begin
         map_we = 1'b1;
         map_wa = {cell_z, cell_y, cell_x};
         map_wd = cell_solid;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we)
         map_mem[map_wa] <= map_wd;
      rd_ff <= map_mem[map_ra];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p_in[k] = p_ff[k];
         d_in[k] = d_ff[k];
         c_in[k] = c_ff[k];
      end
      n_in        = n_ff;
      r_in        = r_ff;
      bit_in      = bit_ff;
      trav_in     = trav_ff;
      best_in     = best_ff;
      bt_in       = bt_ff;
      bplane_in   = bplane_ff;
      bclamp_in   = bclamp_ff;
      bvalid_in   = bvalid_ff;
      hit_in      = hit_ff;
      clr_in      = clr_ff;
      rsp_hit_in  = rsp_hit_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_z_in    = rsp_z_ff;
      case (cmd.op)
         DP_CLEAR: begin
            clr_in = clr_ff + 1'b1;
         end
         DP_LOAD: begin
            p_in[0] = COORD_W'($signed(origin_x));
            p_in[1] = COORD_W'($signed(origin_y));
            p_in[2] = COORD_W'($signed(origin_z));
            d_in[0] = dir_x;
            d_in[1] = dir_y;
            d_in[2] = dir_z;
            c_in[0] = CELL_W'($signed(origin_x) >>> FRAC_BITS);
            c_in[1] = CELL_W'($signed(origin_y) >>> FRAC_BITS);
            c_in[2] = CELL_W'($signed(origin_z) >>> FRAC_BITS);
            n_in    = '0;
            r_in    = '0;
            bit_in  = DIV_W'(1) << (DIV_W - 2);
            trav_in = '0;
            hit_in  = 1'b0;
         end
         DP_SQ: begin
            n_in = n_ff + DIV_W'(sq_prod);
         end
         DP_SQRT: begin
            if (n_ff >= root_try) begin
               n_in = n_ff - root_try;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         DP_STEP_INIT: begin
            bvalid_in = 1'b0;
         end
         DP_PLAN_TAKE: begin
            if (!bvalid_ff || (t_clip < bt_ff)) begin
               bvalid_in = 1'b1;
               best_in   = cmd.axis;
               bt_in     = t_clip;
               bplane_in = plane_q;
               bclamp_in = raw_over;
            end
         end
         DP_ADV_SET: begin
            p_in[cmd.axis] = bplane_ff;
         end
         DP_ADV_TAKE: begin
            p_in[cmd.axis] = d_neg ? p_sel - COORD_W'(step_q) : p_sel + COORD_W'(step_q);
         end
         DP_CELL: begin
            trav_in = trav_ff + TRAV_W'(bt_ff);
            for (int k = 0; k < 3; k++) begin
               c_in[k] = CELL_W'(p_ff[k] >>> FRAC_BITS);
               if ((2'(k) == best_ff) && d_ff[k][FIELD_W-1])
                  c_in[k] = CELL_W'(p_ff[k] >>> FRAC_BITS) - 1'b1;
            end
         end
         DP_MCHK: begin
            hit_in = in_grid && rd_ff;
         end
         DP_OUT: begin
            rsp_hit_in  = hit_ff;
            rsp_dist_in = (trav_ff < TRAV_W'(len)) ? trav_ff[FIELD_W-1:0] : len;
            rsp_x_in    = hit_ff ? c_ff[0][4:0] : '0;
            rsp_y_in    = hit_ff ? c_ff[1][4:0] : '0;
            rsp_z_in    = hit_ff ? c_ff[2][4:0] : '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      for (int k = 0; k < 3; k++) begin
         p_ff[k] <= p_in[k];
         d_ff[k] <= d_in[k];
         c_ff[k] <= c_in[k];
      end
      n_ff        <= n_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      trav_ff     <= trav_in;
      best_ff     <= best_in;
      bt_ff       <= bt_in;
      bplane_ff   <= bplane_in;
      bclamp_ff   <= bclamp_in;
      bvalid_ff   <= bvalid_in;
      hit_ff      <= hit_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
   end

   always_comb begin
      sts.clr_last     = &clr_ff;
      sts.sqrt_last    = bit_ff[0];
      sts.trav_lt_len  = trav_ff < TRAV_W'(len);
      sts.dir_zero     = (d_sel == '0);
      sts.chosen_fixed = (best_ff == cmd.axis) && !bclamp_ff;
      sts.div_done     = div_done;
      sts.hit_now      = in_grid && rd_ff;
   end

   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_hit_x    = rsp_x_ff;
   assign rsp_hit_y    = rsp_y_ff;
   assign rsp_hit_z    = rsp_z_ff;

endmodule

// ===== rtl/vrm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences clear, writes, root, per-axis plans and advances.
module vrm_ctrl
   import vrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_opcode,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     axis_ff, axis_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           last_axis;

   assign last_axis = (axis_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd.op       = DP_NOP;
      cmd.axis     = axis_ff;
      req_tready   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.op = DP_CLEAR;
            if (sts.clr_last)
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_opcode == OP_CAST) begin
                  cmd.op   = DP_LOAD;
                  axis_in  = '0;
                  state_in = ST_SQ;
               end else begin
                  cmd.op = DP_WRITE;
               end
            end
         end
         ST_SQ: begin
            cmd.op  = DP_SQ;
            axis_in = last_axis ? 2'd0 : axis_ff + 1'b1;
            if (last_axis)
               state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op = DP_SQRT;
            if (sts.sqrt_last)
               state_in = ST_LOOP;
         end
         ST_LOOP: begin
            cmd.op  = DP_STEP_INIT;
            axis_in = '0;
            state_in = sts.trav_lt_len ? ST_PLAN : ST_FINISH;
         end
         ST_PLAN: begin
            if (sts.dir_zero) begin
               axis_in = last_axis ? 2'd0 : axis_ff + 1'b1;
               if (last_axis)
                  state_in = ST_ADV;
            end else begin
               cmd.op   = DP_PLAN_START;
               state_in = ST_PWAIT;
            end
         end
         ST_PWAIT: begin
            if (sts.div_done) begin
               cmd.op   = DP_PLAN_TAKE;
               axis_in  = last_axis ? 2'd0 : axis_ff + 1'b1;
               state_in = last_axis ? ST_ADV : ST_PLAN;
            end
         end
         ST_ADV: begin
            if (sts.chosen_fixed || sts.dir_zero) begin
               if (sts.chosen_fixed)
                  cmd.op = DP_ADV_SET;
               axis_in = last_axis ? 2'd0 : axis_ff + 1'b1;
               if (last_axis)
                  state_in = ST_CELL;
            end else begin
               cmd.op   = DP_ADV_START;
               state_in = ST_AWAIT;
            end
         end
         ST_AWAIT: begin
            if (sts.div_done) begin
               cmd.op   = DP_ADV_TAKE;
               axis_in  = last_axis ? 2'd0 : axis_ff + 1'b1;
               state_in = last_axis ? ST_CELL : ST_ADV;
            end
         end
         ST_CELL: begin
            cmd.op   = DP_CELL;
            state_in = ST_MREQ;
         end
         ST_MREQ: begin
            state_in = ST_MCHK;
         end
         ST_MCHK: begin
            cmd.op   = DP_MCHK;
            state_in = sts.hit_now ? ST_FINISH : ST_LOOP;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op       = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/voxel_ray_march.sv =====
`timescale 1ns / 1ps
// Top level of the voxel ray march block: occupancy map and first-hit ray walk.
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------------------
//   req_    | in  | tuser: opcode; tdata: cell x/y/z, solid, origin x/y/z, dir x/y/z
//   rsp_    | out | tuser: hit; tdata: distance, hit x/y/z (one beat per cast)
//
// A write beat is done in its accept cycle. A cast takes its accept cycle, then squaring,
// the root, then per cell step the loop, cell, map read and check states plus, for each
// axis, a plan and an advance, each through the shared serial divider where needed
// (plan: nonzero axis; advance: moved axis that is not the one snapped onto its plane).
// After reset a clearing pass walks the 32768-cell map, one cell a cycle, before
// the first beat is taken. A stalled result sits in the output register and
// does not hold off write beats; the next cast finishes only after it drains.
module voxel_ray_march
   import vrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,    // [0] opcode
   // [4:0] cell_x, [9:5] cell_y, [14:10] cell_z, [15] cell_solid,
   // [31:16] origin_x, [47:32] origin_y, [63:48] origin_z,
   // [79:64] dir_x, [95:80] dir_y, [111:96] dir_z
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,    // [0] hit
   // [15:0] distance, [20:16] hit_x, [25:21] hit_y, [30:26] hit_z, [31] zero
   output logic [31:0]  rsp_tdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [FIELD_W-1:0] rsp_distance;
   logic [4:0]         rsp_hit_x, rsp_hit_y, rsp_hit_z;

   vrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   vrm_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cell_x       (req_tdata[4:0]),
      .cell_y       (req_tdata[9:5]),
      .cell_z       (req_tdata[14:10]),
      .cell_solid   (req_tdata[15]),
      .origin_x     (req_tdata[31:16]),
      .origin_y     (req_tdata[47:32]),
      .origin_z     (req_tdata[63:48]),
      .dir_x        (req_tdata[79:64]),
      .dir_y        (req_tdata[95:80]),
      .dir_z        (req_tdata[111:96]),
      .rsp_hit      (rsp_tuser),
      .rsp_distance (rsp_distance),
      .rsp_hit_x    (rsp_hit_x),
      .rsp_hit_y    (rsp_hit_y),
      .rsp_hit_z    (rsp_hit_z)
   );

   assign rsp_tdata = {1'b0, rsp_hit_z, rsp_hit_y, rsp_hit_x, rsp_distance};

endmodule

// ===== tb/voxel_ray_march_checker.sv =====
`timescale 1ns / 1ps
// Checker for the voxel ray march block: occupancy shadow, cast predictor, result compare.
module voxel_ray_march_checker
   import vrm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         req_tuser,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         rsp_tuser,
   input  logic [31:0]  rsp_tdata,
   output int           fail_count,
   output int           casts_pending
);

   typedef struct packed {
      logic        hit;
      logic [15:0] distance;
      logic [4:0]  hx;
      logic [4:0]  hy;
      logic [4:0]  hz;
   } cast_result_type;

   localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
   localparam longint SIDE  = 64'sd1 << GRID_BITS;

   bit              solid_map [0:(1 << MAP_AW) - 1];
   cast_result_type cast_q [$];

   function automatic longint cell_floor(longint p);
      longint q;
      q = p / ONE_Q;
      if ((p % ONE_Q) != 0 && p < 0) q -= 1;
      return q;
   endfunction

   function automatic longint root_floor(longint n);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= n) r += 1;
      return r;
   endfunction

   function automatic bit solid_at(longint cx, longint cy, longint cz);
      if (cx < 0 || cy < 0 || cz < 0 || cx >= SIDE || cy >= SIDE || cz >= SIDE)
         return 1'b0;
      return solid_map[(cz << (2 * GRID_BITS)) | (cy << GRID_BITS) | cx];
   endfunction

   function automatic cast_result_type march_ray(logic [111:0] d);
      longint p [3];
      longint v [3];
      longint c [3];
      longint len, trav, walk_dist, plane, diff, ad, raw, t, bt, bplane;
      int     best;
      bit     hit, bclamp;
      cast_result_type r;
      len = 0; trav = 0; hit = 0;
      for (int i = 0; i < 3; i++) begin
         p[i] = longint'($signed(d[16 + 16 * i +: 16]));
         v[i] = longint'($signed(d[64 + 16 * i +: 16]));
         len += v[i] * v[i];
         c[i] = cell_floor(p[i]);
      end
      len = root_floor(len);
      while (!hit && trav < len) begin
         best = -1; bt = 0; bplane = 0; bclamp = 0;
         for (int i = 0; i < 3; i++) begin
            if (v[i] == 0) continue;
            if (v[i] > 0) plane = c[i] + 1;
            else plane = (c[i] * ONE_Q == p[i]) ? c[i] - 1 : c[i];
            plane *= ONE_Q;
            diff = v[i] > 0 ? plane - p[i] : p[i] - plane;
            ad   = v[i] > 0 ? v[i] : -v[i];
            raw  = diff * len / ad;
            t    = raw > len ? len : raw;
            if (best < 0 || t < bt) begin
               best = i; bt = t; bplane = plane; bclamp = raw > len;
            end
         end
         if (best < 0) break;
         trav += bt;
         for (int i = 0; i < 3; i++) begin
            if (i == best && !bclamp) p[i] = bplane;
            else p[i] += v[i] * bt / len;
         end
         for (int i = 0; i < 3; i++) c[i] = cell_floor(p[i]);
         if (v[best] < 0) c[best] -= 1;
         hit = solid_at(c[0], c[1], c[2]);
      end
      walk_dist = trav < len ? trav : len;
      if (walk_dist > 65535) walk_dist = 65535;
      if (walk_dist < 0) walk_dist = 0;
      r.hit = hit;
      r.distance = walk_dist[15:0];
      r.hx = hit ? c[0][4:0] : 5'd0;
      r.hy = hit ? c[1][4:0] : 5'd0;
      r.hz = hit ? c[2][4:0] : 5'd0;
      return r;
   endfunction

   assign casts_pending = cast_q.size();

   initial begin
      fail_count = 0;
      foreach (solid_map[k]) solid_map[k] = 1'b0;
   end

   always @(posedge clock) begin
      cast_result_type want, got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (opcode_type'(req_tuser) == OP_WRITE)
               solid_map[{req_tdata[14:10], req_tdata[9:5], req_tdata[4:0]}] = req_tdata[15];
            else
               cast_q.insert(cast_q.size(), march_ray(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[20:16], rsp_tdata[25:21],
                   rsp_tdata[30:26]};
            if (cast_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %h", got);
            end else begin
               want = cast_q.pop_front();
               if (want != got || rsp_tdata[31] !== 1'b0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp %0d/%0d/%0d,%0d,%0d got %0d/%0d/%0d,%0d,%0d",
                              want.hit, want.distance, want.hx, want.hy, want.hz,
                              got.hit, got.distance, got.hx, got.hy, got.hz);
               end
            end
         end
      end
   end

endmodule

// ===== tb/voxel_ray_march_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the voxel ray march block: stimulus, stalls and verdict.
module voxel_ray_march_tb;
   import vrm_pkg::*;

   localparam int WATCHDOG = 400000;   // idle cycles; covers the map clear and a long cast

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic         req_tuser = 0;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic         rsp_tuser;
   logic [31:0]  rsp_tdata;
   int           fail_count;
   int           casts_pending;
   int           idle_cycles = 0;

   always #5 clock = ~clock;

   voxel_ray_march DUT (.*);

   voxel_ray_march_checker u_checker (.*);

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stall: a random gap before each beat, bursts of no stall
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // one beat; the gap is skipped when no_gap is set
   task automatic send_beat(opcode_type op, logic [111:0] data, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic put_cell(logic [4:0] x, y, z, logic s, bit no_gap);
      send_beat(OP_WRITE, 112'({$urandom, $urandom, $urandom, $urandom}) & ~112'hFFFF
                          | {96'd0, s, z, y, x}, no_gap);
   endtask

   task automatic cast_ray(logic [15:0] ox, oy, oz, dx, dy, dz, bit no_gap);
      send_beat(OP_CAST, {dz, dy, dx, oz, oy, ox, 1'($urandom), 15'($urandom)}, no_gap);
   endtask

   // small direction, mostly a few cells long
   function automatic logic [15:0] rnd_dir();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'($signed($urandom_range(0, 4096)) - 2048);
         2: return 16'($urandom);
         default: return 16'($signed($urandom_range(0, 1024)) - 512);
      endcase
   endfunction

   function automatic logic [15:0] rnd_org();
      case ($urandom_range(0, 4))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 31) << FRAC_BITS);   // on a cell face
         default: return 16'($signed($urandom_range(0, 36 * 256)) - 1024);
      endcase
   endfunction

   initial begin
      int n;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: map corners, cells around (4,4,4) and a cleared cell
      put_cell(0, 0, 0, 1, 0);
      put_cell(31, 31, 31, 1, 1);
      put_cell(5, 4, 4, 1, 0);
      put_cell(3, 4, 4, 1, 0);
      put_cell(4, 4, 9, 1, 0);
      put_cell(9, 9, 9, 1, 0);
      put_cell(9, 9, 9, 0, 0);
      cast_ray(16'h0480, 16'h0480, 16'h0480, 16'h0000, 16'h0000, 16'h0000, 0); // zero dir
      cast_ray(16'h0480, 16'h0480, 16'h0480, 16'h0400, 16'h0000, 16'h0000, 1); // +x hit
      cast_ray(16'h0400, 16'h0480, 16'h0480, 16'hFC00, 16'h0000, 16'h0000, 0); // on face, -x
      cast_ray(16'h0480, 16'h0480, 16'h0480, 16'h0000, 16'h0000, 16'h0080, 0); // step ends on a face at ray end
      cast_ray(16'h0480, 16'h0480, 16'h0480, 16'h0000, 16'h0000, 16'h0800, 0); // +z hit
      cast_ray(16'h0180, 16'h0180, 16'h0180, 16'hFE00, 16'hFE00, 16'hFE00, 0); // diag to 0,0,0
      cast_ray(16'h1E80, 16'h1E80, 16'h1E80, 16'h0100, 16'h0100, 16'h0100, 0); // to far corner
      cast_ray(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 0); // field extremes
      cast_ray(16'h0980, 16'h0980, 16'h0980, 16'h0100, 16'h0000, 16'h0000, 0); // cleared cell
      cast_ray(16'hFF00, 16'h0480, 16'h0480, 16'h0800, 16'h0000, 16'h0000, 0); // from outside

      // hold off until every cast has come back
      req_tvalid <= 0;
      while (casts_pending != 0) @(negedge clock);

      // random: writes anywhere and clustered in cells 2 to 8, mixed with random casts
      n = 0;
      while (n < 1600) begin
         if ($urandom_range(0, 2) == 0)
            put_cell(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                     5'($urandom_range(0, 31)),
                     $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0);
         else if ($urandom_range(0, 1) == 0)
            put_cell(5'($urandom_range(2, 8)), 5'($urandom_range(2, 8)),
                     5'($urandom_range(2, 8)),
                     $urandom_range(0, 2) != 0, $urandom_range(0, 3) == 0);
         else
            cast_ray(rnd_org(), rnd_org(), rnd_org(), rnd_dir(), rnd_dir(), rnd_dir(),
                     $urandom_range(0, 3) == 0);
         n++;
      end
      req_tvalid <= 0;

      while (casts_pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fail_count == 0 && casts_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== voxel_ray_march.f =====
rtl/vrm_pkg.sv
rtl/vrm_div.sv
rtl/vrm_dpath.sv
rtl/vrm_ctrl.sv
rtl/voxel_ray_march.sv
tb/voxel_ray_march_checker.sv
tb/voxel_ray_march_tb.sv
